@@ hdl/dmr_pkg.sv @@
// Shared types and constants for the single-button LED dimmer.
`timescale 1ns / 1ps

package dmr_pkg;

   localparam int TIMER_W = 16;
   localparam int LEVEL_W = 7;
   localparam int THRESH_W = 8;
   localparam int CSR_INDEX_W = 2;

   // CSR register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_STEP_TICKS  = 2'd1;

   localparam logic [TIMER_W-1:0] LONG_PRESS_RESET = 16'd300;
   localparam logic [TIMER_W-1:0] RAMP_STEP_RESET  = 16'd100;

   localparam logic [LEVEL_W-1:0] LEVEL_MIN = 7'd1;

   typedef enum logic [1:0] {
      RAMP_IDLE = 2'd0,
      RAMP_UP   = 2'd1,
      RAMP_DOWN = 2'd2
   } ramp_dir_type;

   typedef struct packed {
      logic                light_on;
      logic [LEVEL_W-1:0]  level;
      ramp_dir_type        ramp_dir;
   } dim_status_type;

   typedef struct packed {
      logic [TIMER_W-1:0] long_press_ticks;
      logic [TIMER_W-1:0] ramp_step_ticks;
   } dim_cfg_type;

   // zero in a timer register acts as one
   function automatic logic [TIMER_W-1:0] at_least_one(input logic [TIMER_W-1:0] v);
      at_least_one = (v == '0) ? {{(TIMER_W-1){1'b0}}, 1'b1} : v;
   endfunction

endpackage

@@ hdl/dmr_ctrl.sv @@
// Dimmer state registers and the per-tick button, press timer and ramp update.
`timescale 1ns / 1ps

module dmr_ctrl #(
   parameter int LEVEL_MAX = 100
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tick_en,
   input  logic                  button_pin,
   input  dmr_pkg::dim_cfg_type  cfg,
   output dmr_pkg::dim_status_type status_next
);
   import dmr_pkg::*;

   localparam logic [LEVEL_W-1:0] LevelTop = LEVEL_W'(LEVEL_MAX);

   logic               lamp_on_ff, lamp_on_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               held_ff, held_in;
   logic               pending_ff, pending_in;
   logic [TIMER_W-1:0] press_count_ff, press_count_in;
   ramp_dir_type       dir_ff, dir_in;
   logic [TIMER_W-1:0] ramp_count_ff, ramp_count_in;

   always_comb begin
      logic armed;
      logic expired;
      logic do_step;
      armed    = 1'b0;
      expired  = 1'b0;
      do_step  = 1'b0;
      lamp_on_in     = lamp_on_ff;
      level_in       = level_ff;
      held_in        = held_ff;
      pending_in     = pending_ff;
      press_count_in = press_count_ff;
      dir_in         = dir_ff;
      ramp_count_in  = ramp_count_ff;

      // button edges
      if (!button_pin) begin
         if (!held_ff) begin
            held_in        = 1'b1;
            pending_in     = 1'b1;
            press_count_in = at_least_one(cfg.long_press_ticks);
            armed          = 1'b1;
         end
      end else begin
         if (held_ff) begin
            if (!pending_ff) begin
               dir_in = RAMP_IDLE;
            end else begin
               pending_in = 1'b0;
               lamp_on_in = !lamp_on_ff;
            end
         end
         held_in = 1'b0;
      end

      // press timer
      if (pending_in && !armed) begin
         press_count_in = press_count_in - 1'b1;
         if (press_count_in == '0) begin
            pending_in = 1'b0;
            dir_in     = lamp_on_in ? RAMP_DOWN : RAMP_UP;
            expired    = 1'b1;
            do_step    = 1'b1;
         end
      end

      // ramp timer, skipped in a tick where the press timer expired
      if (dir_in != RAMP_IDLE && !expired) begin
         ramp_count_in = ramp_count_in - 1'b1;
         if (ramp_count_in == '0) begin
            do_step = 1'b1;
         end
      end

      // at most one ramp step per tick
      if (do_step) begin
         case (dir_in)
            RAMP_UP: begin
               lamp_on_in = 1'b1;
               if (level_in < LevelTop) begin
                  level_in = level_in + 1'b1;
               end else begin
                  level_in = LevelTop;
               end
               if (level_in >= LevelTop) begin
                  dir_in = RAMP_IDLE;
               end
            end
            RAMP_DOWN: begin
               level_in = (level_in > LEVEL_MIN) ? level_in - 1'b1 : LEVEL_MIN;
               if (level_in == LEVEL_MIN) begin
                  lamp_on_in = 1'b0;
                  dir_in     = RAMP_IDLE;
               end
            end
            default: begin
               dir_in = RAMP_IDLE;
            end
         endcase
         if (dir_in != RAMP_IDLE) begin
            ramp_count_in = at_least_one(cfg.ramp_step_ticks);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lamp_on_ff     <= 1'b0;
         level_ff       <= LEVEL_MIN;
         held_ff        <= 1'b0;
         pending_ff     <= 1'b0;
         press_count_ff <= '0;
         dir_ff         <= RAMP_IDLE;
         ramp_count_ff  <= '0;
      end else if (tick_en) begin
         lamp_on_ff     <= lamp_on_in;
         level_ff       <= level_in;
         held_ff        <= held_in;
         pending_ff     <= pending_in;
         press_count_ff <= press_count_in;
         dir_ff         <= dir_in;
         ramp_count_ff  <= ramp_count_in;
      end
   end

   assign status_next.light_on = lamp_on_in;
   assign status_next.level    = level_in;
   assign status_next.ramp_dir = dir_in;

endmodule

@@ hdl/dmr_scale.sv @@
// Level to PWM duty threshold lookup, level*255/LEVEL_MAX.
`timescale 1ns / 1ps

module dmr_scale #(
   parameter int LEVEL_MAX = 100
) (
   input  logic [dmr_pkg::LEVEL_W-1:0]  level,
   output logic [dmr_pkg::THRESH_W-1:0] threshold
);
   import dmr_pkg::*;

   localparam int TableDepth = 2 ** LEVEL_W;
   localparam int FullScale  = 2 ** THRESH_W - 1;

   logic [THRESH_W-1:0] scale_lut [TableDepth];

   // entries above LEVEL_MAX are never addressed
   for (genvar g = 0; g < TableDepth; g++) begin : g_lut
      assign scale_lut[g] = THRESH_W'((g * FullScale) / LEVEL_MAX);
   end

   assign threshold = scale_lut[level];

endmodule

@@ hdl/single_button_led_dimmer_unit.sv @@
// Top level of the single-button toggle and ramp LED dimmer.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------------------
//  req     | in        | req_valid/stall   | req_button_pin (active low)
//  rsp     | out       | rsp_valid/stall   | light_on, pwm_threshold, level, ramp_state
//  csr     | in        | csr_valid/ready   | csr_index, csr_wdata
//
// One tick per cycle sustained while rsp_stall stays low; a transaction's result reaches
// the rsp ports through the input register, then the result register.
// The dimmer state advances as a tick moves from the input register to the
// result register; a stalled result holds the tick in the input register.
// Synchronous active-high reset: light off, level 1, ramp idle, timers 300/100.
// The csr port is always ready.
`timescale 1ns / 1ps

module single_button_led_dimmer_unit #(
   parameter int LEVEL_MAX = 100
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_button_pin,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_light_on,
   output logic [dmr_pkg::THRESH_W-1:0]       rsp_pwm_threshold,
   output logic [dmr_pkg::LEVEL_W-1:0]        rsp_brightness_level,
   output logic [1:0]                         rsp_ramp_state,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dmr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dmr_pkg::TIMER_W-1:0]        csr_wdata
);
   import dmr_pkg::*;

   dim_cfg_type         cfg_ff;
   logic                in_valid_ff;
   logic                in_pin_ff;
   logic                rsp_valid_ff;
   logic                light_on_ff;
   logic [THRESH_W-1:0] threshold_ff;
   logic [LEVEL_W-1:0]  level_ff;
   ramp_dir_type        ramp_dir_ff;

   logic                advance;
   logic                req_take;
   dim_status_type      status_next;
   logic [THRESH_W-1:0] threshold_next;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks <= LONG_PRESS_RESET;
         cfg_ff.ramp_step_ticks  <= RAMP_STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LONG_PRESS_TICKS: cfg_ff.long_press_ticks <= csr_wdata;
            CSR_RAMP_STEP_TICKS:  cfg_ff.ramp_step_ticks  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pin_ff <= req_button_pin;
      end
      if (advance) begin
         light_on_ff  <= status_next.light_on;
         threshold_ff <= threshold_next;
         level_ff     <= status_next.level;
         ramp_dir_ff  <= status_next.ramp_dir;
      end
   end

   dmr_ctrl #(
      .LEVEL_MAX (LEVEL_MAX)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .tick_en     (advance),
      .button_pin  (in_pin_ff),
      .cfg         (cfg_ff),
      .status_next (status_next)
   );

   dmr_scale #(
      .LEVEL_MAX (LEVEL_MAX)
   ) u_scale (
      .level     (status_next.level),
      .threshold (threshold_next)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_light_on         = light_on_ff;
   assign rsp_pwm_threshold    = threshold_ff;
   assign rsp_brightness_level = level_ff;
   assign rsp_ramp_state       = ramp_dir_ff;

endmodule

@@ bench/tb_single_button_led_dimmer_unit.sv @@
// Self-checking testbench for the single-button LED dimmer unit.
`timescale 1ns / 1ps

module tb_single_button_led_dimmer_unit;
   import dmr_pkg::*;

   localparam int LEVEL_TOP = 100;

   typedef struct {
      bit                  light;
      logic [THRESH_W-1:0] thresh;
      logic [LEVEL_W-1:0]  level;
      ramp_dir_type        dir;
   } tick_result_type;

   // Tracks the dimmer state and holds the results still owed by the block.
   class dimmer_scoreboard;
      logic [TIMER_W-1:0] long_press_cfg;
      logic [TIMER_W-1:0] ramp_step_cfg;
      bit                 lamp;
      logic [LEVEL_W-1:0] level;
      bit                 held;
      bit                 pending;
      logic [TIMER_W-1:0] press_left;
      logic [TIMER_W-1:0] ramp_left;
      ramp_dir_type       dir;
      tick_result_type    expected_q[$];
      int unsigned        errors;
      int unsigned        checked;
      int unsigned        ramp_ticks;
      int unsigned        full_ticks;
      int unsigned        toggles;

      function new();
         long_press_cfg = LONG_PRESS_RESET;
         ramp_step_cfg  = RAMP_STEP_RESET;
         lamp       = 1'b0;
         level      = LEVEL_MIN;
         held       = 1'b0;
         pending    = 1'b0;
         press_left = '0;
         ramp_left  = '0;
         dir        = RAMP_IDLE;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [TIMER_W-1:0] value);
         if (idx == CSR_LONG_PRESS_TICKS) begin
            long_press_cfg = value;
         end else if (idx == CSR_RAMP_STEP_TICKS) begin
            ramp_step_cfg = value;
         end
      endfunction

      function void step_ramp();
         case (dir)
            RAMP_UP: begin
               lamp = 1'b1;
               if (level < LEVEL_TOP) level = level + 1'b1;
               if (level >= LEVEL_TOP) dir = RAMP_IDLE;
            end
            RAMP_DOWN: begin
               if (level > LEVEL_MIN) level = level - 1'b1;
               if (level == LEVEL_MIN) begin
                  lamp = 1'b0;
                  dir  = RAMP_IDLE;
               end
            end
            default: dir = RAMP_IDLE;
         endcase
         if (dir != RAMP_IDLE) ramp_left = (ramp_step_cfg == '0) ? 16'd1 : ramp_step_cfg;
      endfunction

      // advance one tick; button_pin is active low
      function void note_tick(bit button_pin);
         bit              armed;
         bit              stepped;
         tick_result_type res;
         armed   = 1'b0;
         stepped = 1'b0;
         if (!button_pin) begin
            if (!held) begin
               held       = 1'b1;
               pending    = 1'b1;
               press_left = (long_press_cfg == '0) ? 16'd1 : long_press_cfg;
               armed      = 1'b1;
            end
         end else begin
            if (held) begin
               if (!pending) begin
                  dir = RAMP_IDLE;
               end else begin
                  pending = 1'b0;
                  lamp    = !lamp;
                  toggles++;
               end
            end
            held = 1'b0;
         end
         // press timer does not count on its arming tick
         if (pending && !armed) begin
            press_left = press_left - 1'b1;
            if (press_left == '0) begin
               pending = 1'b0;
               dir     = lamp ? RAMP_DOWN : RAMP_UP;
               step_ramp();
               stepped = 1'b1;
            end
         end
         if (dir != RAMP_IDLE && !stepped) begin
            ramp_left = ramp_left - 1'b1;
            if (ramp_left == '0) step_ramp();
         end
         res.light  = lamp;
         res.thresh = THRESH_W'((int'(level) * 255) / LEVEL_TOP);
         res.level  = level;
         res.dir    = dir;
         expected_q.push_back(res);
      endfunction

      function void check_result(logic light, logic [THRESH_W-1:0] thresh,
                                 logic [LEVEL_W-1:0] lvl, logic [1:0] state);
         tick_result_type exp_res;
         if (expected_q.size() == 0) begin
            $error("result transaction with no tick outstanding");
            errors++;
            return;
         end
         exp_res = expected_q.pop_front();
         checked++;
         if (exp_res.dir != RAMP_IDLE) ramp_ticks++;
         if (exp_res.level == LEVEL_TOP) full_ticks++;
         if (light !== exp_res.light) begin
            $error("light_on: expected %0d, got %0d", exp_res.light, light);
            errors++;
         end
         if (thresh !== exp_res.thresh) begin
            $error("pwm_threshold: expected %0d, got %0d", exp_res.thresh, thresh);
            errors++;
         end
         if (lvl !== exp_res.level) begin
            $error("brightness_level: expected %0d, got %0d", exp_res.level, lvl);
            errors++;
         end
         if (state !== exp_res.dir) begin
            $error("ramp_state: expected %0d, got %0d", exp_res.dir, state);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_button_pin = 1'b1;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_light_on;
   logic [THRESH_W-1:0]    rsp_pwm_threshold;
   logic [LEVEL_W-1:0]     rsp_brightness_level;
   logic [1:0]             rsp_ramp_state;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_LONG_PRESS_TICKS;
   logic [TIMER_W-1:0]     csr_wdata = '0;

   dimmer_scoreboard sb = new();

   int unsigned sender_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned ticks_sent = 0;
   int unsigned settings_used = 0;
   int          cur_long_press = int'(LONG_PRESS_RESET);
   int          cur_ramp_step = int'(RAMP_STEP_RESET);

   single_button_led_dimmer_unit #(.LEVEL_MAX(LEVEL_TOP)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_button_pin(req_button_pin),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_light_on(rsp_light_on),
      .rsp_pwm_threshold(rsp_pwm_threshold),
      .rsp_brightness_level(rsp_brightness_level),
      .rsp_ramp_state(rsp_ramp_state),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_light_on, rsp_pwm_threshold, rsp_brightness_level,
                         rsp_ramp_state);
      end
   end

   task automatic send_tick(bit pin);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_button_pin <= pin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_tick(pin);
      ticks_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [TIMER_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, value);
      if (idx == CSR_LONG_PRESS_TICKS) cur_long_press = int'(value);
      else cur_ramp_step = int'(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_timers(logic [TIMER_W-1:0] long_press, logic [TIMER_W-1:0] ramp_step);
      write_reg(CSR_LONG_PRESS_TICKS, long_press);
      write_reg(CSR_RAMP_STEP_TICKS, ramp_step);
      settings_used++;
   endtask

   task automatic send_pattern(string pattern);
      for (int i = 0; i < pattern.len(); i++) send_tick(pattern[i] == "1");
   endtask

   // mostly clean press/release gestures around the long-press point, some noise
   task automatic play_presses(int unsigned count);
      int unsigned stop_at;
      int          lp;
      int          rs;
      int          hold;
      stop_at = ticks_sent + count;
      lp = (cur_long_press == 0) ? 1 : cur_long_press;
      rs = (cur_ramp_step == 0) ? 1 : cur_ramp_step;
      while (ticks_sent < stop_at) begin
         case ($urandom_range(9))
            0, 1, 2: hold = $urandom_range(1, (lp > 1) ? lp - 1 : 1);
            3:       hold = lp - 1 + $urandom_range(0, 2);
            4, 5:    hold = lp + $urandom_range(0, 20 * rs);
            6, 7:    hold = lp + $urandom_range(0, 110 * rs);
            default: hold = 0;
         endcase
         if (hold > 240) hold = 240;
         if (hold == 0) begin
            repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(1)));
         end else begin
            repeat (hold) send_tick(1'b0);
            repeat ($urandom_range(1, 6)) send_tick(1'b1);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short press at reset timers, then fast timers for both ramp directions
      send_pattern("1011");
      drain();
      set_timers(16'd2, 16'd1);
      send_pattern("000001");
      send_pattern("00000001");
      send_pattern("0101");
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 4)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 81; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 81; end
            default: begin sender_idle_pct = 12; stall_pct = 12; end
         endcase
         case (phase)
            0: set_timers(16'd3, 16'd1);
            1: set_timers(16'd1, 16'd2);
            2: set_timers(16'd0, 16'd0);
            3: set_timers(16'd6, 16'd1);
            4: set_timers(16'd2, 16'hFFFF);
            default: set_timers(16'hFFFF, 16'($urandom_range(0, 3)));
         endcase
         play_presses(210);
         drain();
      end

      sender_idle_pct = 0;
      stall_pct = 0;
      repeat (8) @(posedge clock);
      if (sb.expected_q.size() != 0) begin
         $error("%0d results never arrived", sb.expected_q.size());
         sb.errors++;
      end
      $display("%0d ticks checked across %0d timer settings and four idle patterns",
               sb.checked, settings_used);
      $display("%0d ticks while ramping, %0d at full level, %0d toggles by short press",
               sb.ramp_ticks, sb.full_ticks, sb.toggles);
      if (sb.errors == 0) begin
         $display("tb_single_button_led_dimmer_unit: clean");
      end else begin
         $display("tb_single_button_led_dimmer_unit: errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_single_button_led_dimmer_unit: errors");
      $finish;
   end

endmodule
